FILE: hw/rtl/ptdt_pkg.sv
`timescale 1ns / 1ps

package ptdt_pkg;

   // table depth and the number of entries one tick may walk
   localparam int MAX_TASKS   = 16;
   localparam int TASK_ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int WALK_CAP    = (MAX_TASKS < 16) ? MAX_TASKS : 16;

   // field widths
   localparam int ACTION_W = 2;
   localparam int TICK_W   = 32;
   localparam int INDEX_W  = 4;
   localparam int TIME_W   = 16;
   localparam int STATUS_W = 3;
   localparam int ACTIVE_W = 5;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [TICK_W-1:0]   tick_type;
   typedef logic [INDEX_W-1:0]  index_type;
   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [ACTIVE_W-1:0] active_type;

   // actions
   localparam action_type ACT_TICK   = 2'd0;
   localparam action_type ACT_LOAD   = 2'd1;
   localparam action_type ACT_FINISH = 2'd2;

   // task states
   localparam status_type ST_WAIT_FNS = 3'd0;
   localparam status_type ST_WAIT_TMT = 3'd1;
   localparam status_type ST_READY    = 3'd2;
   localparam status_type ST_FINISH   = 3'd3;
   localparam status_type ST_TIMEOUT  = 3'd4;

   typedef struct packed {
      time_type period;
      time_type release_offset;
      time_type deadline;
   } task_param_type;

endpackage

FILE: hw/rtl/ptdt_req_if.sv
`timescale 1ns / 1ps

interface ptdt_req_if;
   import ptdt_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   tick_type   tick_value;
   index_type  task_index;
   time_type   period;
   time_type   release_offset;
   time_type   deadline;

   modport source (
      output valid, action, tick_value, task_index, period, release_offset, deadline,
      input  ready
   );

   modport sink (
      input  valid, action, tick_value, task_index, period, release_offset, deadline,
      output ready
   );
endinterface

FILE: hw/rtl/ptdt_rsp_if.sv
`timescale 1ns / 1ps

interface ptdt_rsp_if;
   import ptdt_pkg::*;

   logic       valid;
   logic       ready;
   index_type  task_id;
   status_type task_status;
   logic       deadline_missed;
   logic       work_cleared;
   logic       last;

   modport source (
      output valid, task_id, task_status, deadline_missed, work_cleared, last,
      input  ready
   );

   modport sink (
      input  valid, task_id, task_status, deadline_missed, work_cleared, last,
      output ready
   );
endinterface

FILE: hw/rtl/periodic_task_deadline_tracker_unit.sv
`timescale 1ns / 1ps

// periodic task deadline tracker: a table of up to sixteen periodic tasks held in two
// single-port synchronous rams (parameters and status), worked on one beat at a time.
// a tick beat walks entries 0 to active_tasks-1 and returns one result beat per entry,
// the final one flagged last; each entry passes through a ram read, a radix-4
// remainder unit that forms tick mod period and deadline mod period side by side,
// and a status update with write-back.  a load beat and a finish beat each return a
// single result beat.  action 3 is swallowed with no result.  the result sits in an
// output register so the walk carries on while a beat waits to be taken.  reading an
// entry that was never loaded returns undefined status.  active_tasks is to be written
// through the csr port only while idle (the block itself does not enforce this) and is
// saturated to 1..16.

module periodic_task_deadline_tracker_unit (
   input  logic                      clock,
   input  logic                      reset,
   ptdt_req_if.sink                  req_bus,
   ptdt_rsp_if.source                rsp_bus,
   input  logic                      csr_wr_en,
   input  ptdt_pkg::active_type      csr_wr_data
);
   import ptdt_pkg::*;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   localparam active_type WALK_CAP_V = ACTIVE_W'(WALK_CAP);
   localparam int         REM_W      = TIME_W + 1;

   typedef logic [REM_W-1:0] rem_type;

   // one restoring remainder step: shift in one dividend bit, subtract if it fits
   function automatic rem_type rem_step(rem_type rem, logic dbit, rem_type divisor);
      logic [REM_W:0] trial;
      trial = {rem, dbit};
      if (trial >= {1'b0, divisor}) begin
         trial = trial - {1'b0, divisor};
      end
      return trial[REM_W-1:0];
   endfunction

   // task tables
   task_param_type param_mem [MAX_TASKS];
   status_type     status_mem [MAX_TASKS];

   logic [1:0]     state_ff, state_in;
   active_type     active_ff;
   action_type     act_ff;
   tick_type       tick_ff;
   index_type      index_ff;
   task_param_type load_ff;
   index_type      entry_ff, entry_in;
   index_type      last_ff;
   logic [3:0]     div_cnt_ff;
   rem_type        rem_t_ff, rem_d_ff;
   task_param_type par_rd_ff;
   status_type     st_rd_ff;

   logic           rsp_valid_ff;
   index_type      rsp_id_ff;
   status_type     rsp_status_ff;
   logic           rsp_miss_ff;
   logic           rsp_clr_ff;
   logic           rsp_last_ff;

   logic                   req_fire;
   logic                   slot_free;
   logic                   resp_fire;
   logic                   in_range;
   logic [TASK_ADDR_W-1:0] mem_addr;
   active_type             walk_n;
   rem_type                divisor;
   tick_type               dl_word;
   logic [4:0]             bit_hi, bit_lo;
   rem_type                rem_t_mid, rem_d_mid;

   // result of the update cycle
   status_type res_status;
   index_type  res_id;
   logic       res_miss, res_clr, res_last;
   logic       par_we, st_we;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign resp_fire     = (state_ff == S_RESP) && slot_free;
   assign in_range      = int'(index_ff) < MAX_TASKS;

   // tick walks by entry counter, load and finish by the beat's index
   assign mem_addr = (act_ff == ACT_TICK) ? TASK_ADDR_W'(entry_ff) : TASK_ADDR_W'(index_ff);

   // saturate the active count to 1..cap
   always_comb begin
      walk_n = active_ff;
      if (active_ff == '0) begin
         walk_n = ACTIVE_W'(1);
      end else if (active_ff > WALK_CAP_V) begin
         walk_n = WALK_CAP_V;
      end
   end

   // a stored zero period means 65536
   assign divisor = (par_rd_ff.period == '0) ? {1'b1, {TIME_W{1'b0}}}
                                              : {1'b0, par_rd_ff.period};
   assign dl_word = {{(TICK_W-TIME_W){1'b0}}, par_rd_ff.deadline};

   // two dividend bits per cycle, msb first: bits 31-2c and 30-2c
   assign bit_hi = {~div_cnt_ff, 1'b1};
   assign bit_lo = {~div_cnt_ff, 1'b0};

   assign rem_t_mid = rem_step(rem_t_ff, tick_ff[bit_hi], divisor);
   assign rem_d_mid = rem_step(rem_d_ff, dl_word[bit_hi], divisor);

   // status update for the current beat
   always_comb begin
      res_status = ST_WAIT_FNS;
      res_id     = index_ff;
      res_miss   = 1'b0;
      res_clr    = 1'b0;
      res_last   = 1'b1;
      par_we     = 1'b0;
      st_we      = 1'b0;
      case (act_ff)
         ACT_TICK: begin
            res_id     = entry_ff;
            res_last   = (entry_ff == last_ff);
            res_status = st_rd_ff;
            st_we      = resp_fire;
            case (st_rd_ff)
               ST_WAIT_FNS, ST_WAIT_TMT: begin
                  if (rem_t_ff == {1'b0, par_rd_ff.release_offset}) begin
                     res_status = ST_READY;
                  end
               end
               ST_READY: begin
                  if (rem_t_ff == rem_d_ff) begin
                     res_miss   = 1'b1;
                     res_clr    = 1'b1;
                     res_status = ST_TIMEOUT;
                     // deadline falls on the period boundary: re-arm in the same tick
                     if (rem_t_ff == '0) begin
                        res_status = (par_rd_ff.release_offset == '0) ? ST_READY
                                                                        : ST_WAIT_TMT;
                     end
                  end
               end
               ST_FINISH: begin
                  res_clr = 1'b1;
                  if (rem_t_ff == '0) begin
                     res_status = (par_rd_ff.release_offset == '0) ? ST_READY : ST_WAIT_FNS;
                  end
               end
               ST_TIMEOUT: begin
                  if (rem_t_ff == '0) begin
                     res_status = (par_rd_ff.release_offset == '0) ? ST_READY : ST_WAIT_TMT;
                  end
               end
               default: begin
                  res_status = st_rd_ff;
               end
            endcase
         end
         ACT_LOAD: begin
            par_we = resp_fire && in_range;
            st_we  = resp_fire && in_range;
         end
         ACT_FINISH: begin
            if (in_range) begin
               res_status = (st_rd_ff == ST_READY) ? ST_FINISH : st_rd_ff;
            end
            st_we = resp_fire && in_range;
         end
         default: begin
            res_status = ST_WAIT_FNS;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               entry_in = '0;
               case (req_bus.action)
                  ACT_TICK:   state_in = S_READ;
                  ACT_LOAD:   state_in = S_RESP;
                  ACT_FINISH: state_in = S_READ;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            state_in = (act_ff == ACT_TICK) ? S_DIV : S_RESP;
         end
         S_DIV: begin
            if (div_cnt_ff == '1) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               if (act_ff == ACT_TICK && !res_last) begin
                  entry_in = entry_ff + 1'b1;
                  state_in = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= ACTIVE_W'(1);
         rsp_valid_ff <= 1'b0;
         entry_ff     <= '0;
      end else begin
         state_ff <= state_in;
         entry_ff <= entry_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         if (resp_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // beat capture, remainder unit and result register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff                 <= req_bus.action;
         tick_ff                <= req_bus.tick_value;
         index_ff               <= req_bus.task_index;
         load_ff.period         <= req_bus.period;
         load_ff.release_offset <= req_bus.release_offset;
         load_ff.deadline       <= req_bus.deadline;
         last_ff                <= INDEX_W'(walk_n - 1'b1);
      end
      if (state_ff == S_READ) begin
         div_cnt_ff <= '0;
         rem_t_ff   <= '0;
         rem_d_ff   <= '0;
      end else if (state_ff == S_DIV) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         rem_t_ff   <= rem_step(rem_t_mid, tick_ff[bit_lo], divisor);
         rem_d_ff   <= rem_step(rem_d_mid, dl_word[bit_lo], divisor);
      end
      if (resp_fire) begin
         rsp_id_ff     <= res_id;
         rsp_status_ff <= res_status;
         rsp_miss_ff   <= res_miss;
         rsp_clr_ff    <= res_clr;
         rsp_last_ff   <= res_last;
      end
   end

   // task rams, read data registered
   always_ff @(posedge clock) begin
      if (par_we) begin
         param_mem[mem_addr] <= load_ff;
      end
      if (st_we) begin
         status_mem[mem_addr] <= res_status;
      end
      if (state_ff == S_READ) begin
         par_rd_ff <= param_mem[mem_addr];
         st_rd_ff  <= status_mem[mem_addr];
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.task_id         = rsp_id_ff;
   assign rsp_bus.task_status     = rsp_status_ff;
   assign rsp_bus.deadline_missed = rsp_miss_ff;
   assign rsp_bus.work_cleared    = rsp_clr_ff;
   assign rsp_bus.last            = rsp_last_ff;

endmodule
